FILE: rtl/core/xmodem_checksum_block_sender_macros.svh
// Assertion macros shared by the checker of the XMODEM checksum sender.
`ifndef XMODEM_CHECKSUM_BLOCK_SENDER_MACROS_SVH
`define XMODEM_CHECKSUM_BLOCK_SENDER_MACROS_SVH

// Same-cycle implication, sampled on clk and idle while rst is high.
`define XCS_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("xcs checker: property violated");

// Next-cycle implication, sampled on clk and idle while rst is high.
`define XCS_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("xcs checker: property violated");

`endif

FILE: rtl/core/xcs_pkg.sv
// Package with the types, codes and constants of the XMODEM checksum sender.
package xcs_pkg;

  localparam int BLOCK_BYTES = 128;
  localparam int STORE_AW    = $clog2(BLOCK_BYTES);

  // Frame positions: SOH, number, inverted number, data, checksum.
  localparam logic [7:0] DATA_START    = 8'd3;
  localparam logic [7:0] CHECKSUM_POS  = 8'(BLOCK_BYTES + 3);
  localparam logic [7:0] FRAME_LEN     = 8'(BLOCK_BYTES + 4);
  localparam logic [7:0] BLOCK_BYTES_W = 8'(BLOCK_BYTES);

  // Link characters.
  localparam logic [7:0] CH_SOH = 8'd1;
  localparam logic [7:0] CH_EOT = 8'd4;
  localparam logic [7:0] CH_ACK = 8'd6;
  localparam logic [7:0] CH_NAK = 8'd21;
  localparam logic [7:0] CH_CAN = 8'd24;
  localparam logic [7:0] CH_PAD = 8'd26;

  localparam logic [7:0] RETRY_LIMIT_RESET = 8'd10;
  localparam logic [1:0] ADDR_RETRY_LIMIT  = 2'd0;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_EOF     = 2'd1,
    CMD_TX_SLOT = 2'd2,
    CMD_RX_BYTE = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    PH_WAIT_START = 4'd0,
    PH_ACK_PEND   = 4'd1,
    PH_LOADING    = 4'd2,
    PH_SENDING    = 4'd3,
    PH_WAIT_REPLY = 4'd4,
    PH_EOT_PEND   = 4'd5,
    PH_WAIT_FINAL = 4'd6,
    PH_DONE       = 4'd7,
    PH_CANCELLED  = 4'd8,
    PH_FAILED     = 4'd9,
    PH_DONE_NOACK = 4'd10
  } phase_t;

  localparam logic [2:0] ST_WAIT_START = 3'd0;
  localparam logic [2:0] ST_LOADING    = 3'd1;
  localparam logic [2:0] ST_SENDING    = 3'd2;
  localparam logic [2:0] ST_WAIT_REPLY = 3'd3;
  localparam logic [2:0] ST_DONE       = 3'd4;
  localparam logic [2:0] ST_CANCELLED  = 3'd5;
  localparam logic [2:0] ST_FAILED     = 3'd6;
  localparam logic [2:0] ST_DONE_NOACK = 3'd7;

  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] waddr;
    logic [7:0]          wdata;
    logic [STORE_AW-1:0] raddr;
  } store_req_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [2:0] session_status;
    logic       ready_for_data;
    logic [7:0] current_block;
  } result_t;

  function automatic logic [2:0] status_of_phase(input phase_t ph);
    logic [2:0] st;
    unique case (ph)
      PH_WAIT_START, PH_ACK_PEND: st = ST_WAIT_START;
      PH_LOADING:                 st = ST_LOADING;
      PH_SENDING, PH_EOT_PEND:    st = ST_SENDING;
      PH_WAIT_REPLY, PH_WAIT_FINAL: st = ST_WAIT_REPLY;
      PH_DONE:                    st = ST_DONE;
      PH_CANCELLED:               st = ST_CANCELLED;
      PH_DONE_NOACK:              st = ST_DONE_NOACK;
      default:                    st = ST_FAILED;
    endcase
    return st;
  endfunction

endpackage

FILE: rtl/core/xcs_store.sv
// Block store: 128-byte memory with one write port and a registered read port.
module xcs_store (
  input  logic                clk,
  input  xcs_pkg::store_req_t req,
  output logic [7:0]          rd_data
);
  import xcs_pkg::*;

  logic [7:0] mem [BLOCK_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule

FILE: rtl/core/xcs_cfg.sv
// APB-style configuration register file holding the retry limit.
module xcs_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  retry_limit
);
  import xcs_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == ADDR_RETRY_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= RETRY_LIMIT_RESET;
    end else if (wr_en) begin
      retry_limit <= pwdata[7:0];
    end
  end

  assign prdata = (paddr == ADDR_RETRY_LIMIT) ? {24'd0, retry_limit} : 32'd0;

endmodule

FILE: rtl/core/xcs_ctrl.sv
// Session sequencer: phase machine, block framing, checksum and retry count.
module xcs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic [1:0]          cmd,
  input  logic [7:0]          data_byte,
  input  logic [7:0]          retry_limit,
  input  logic [7:0]          rd_data,
  output xcs_pkg::store_req_t store_req,
  output xcs_pkg::result_t    result
);
  import xcs_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] fill_count, fill_count_next;
  logic [7:0] send_index, send_index_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] block_number, block_number_next;
  logic [7:0] retries_left, retries_left_next;
  logic       final_block, final_block_next;

  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       store_we;
  logic [7:0] data_idx;
  logic [7:0] data_sel;
  logic [7:0] raddr_full;

  // Position inside the data field; bytes past the fill count are padding.
  assign data_idx = send_index - DATA_START;
  assign data_sel = (data_idx < fill_count) ? rd_data : CH_PAD;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT_START;
      fill_count   <= 8'd0;
      send_index   <= 8'd0;
      running_sum  <= 8'd0;
      block_number <= 8'd1;
      retries_left <= RETRY_LIMIT_RESET;
      final_block  <= 1'b0;
    end else begin
      phase        <= phase_next;
      fill_count   <= fill_count_next;
      send_index   <= send_index_next;
      running_sum  <= running_sum_next;
      block_number <= block_number_next;
      retries_left <= retries_left_next;
      final_block  <= final_block_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    fill_count_next   = fill_count;
    send_index_next   = send_index;
    running_sum_next  = running_sum;
    block_number_next = block_number;
    retries_left_next = retries_left;
    final_block_next  = final_block;
    tx_valid          = 1'b0;
    tx_byte           = 8'd0;
    store_we          = 1'b0;

    if (in_fire) begin
      unique case (cmd_t'(cmd))
        CMD_LOAD: begin
          if (phase == PH_LOADING && fill_count < BLOCK_BYTES_W) begin
            store_we        = 1'b1;
            fill_count_next = fill_count + 8'd1;
            if (fill_count_next >= BLOCK_BYTES_W) begin
              final_block_next  = 1'b0;
              send_index_next   = 8'd0;
              running_sum_next  = 8'd0;
              retries_left_next = retry_limit;
              phase_next        = PH_SENDING;
            end
          end
        end
        CMD_EOF: begin
          if (phase == PH_LOADING) begin
            if (fill_count == 8'd0) begin
              phase_next = PH_EOT_PEND;
            end else begin
              final_block_next  = 1'b1;
              send_index_next   = 8'd0;
              running_sum_next  = 8'd0;
              retries_left_next = retry_limit;
              phase_next        = PH_SENDING;
            end
          end
        end
        CMD_TX_SLOT: begin
          if (phase == PH_ACK_PEND) begin
            tx_valid        = 1'b1;
            tx_byte         = CH_ACK;
            fill_count_next = 8'd0;
            phase_next      = PH_LOADING;
          end else if (phase == PH_SENDING) begin
            tx_valid = 1'b1;
            if (send_index == 8'd0) begin
              tx_byte          = CH_SOH;
              running_sum_next = 8'd0;
            end else if (send_index == 8'd1) begin
              tx_byte = block_number;
            end else if (send_index == 8'd2) begin
              tx_byte = ~block_number;
            end else if (send_index < CHECKSUM_POS) begin
              tx_byte          = data_sel;
              running_sum_next = running_sum + data_sel;
            end else begin
              tx_byte = running_sum;
            end
            send_index_next = send_index + 8'd1;
            if (send_index_next >= FRAME_LEN) begin
              phase_next = PH_WAIT_REPLY;
            end
          end else if (phase == PH_EOT_PEND) begin
            tx_valid   = 1'b1;
            tx_byte    = CH_EOT;
            phase_next = PH_WAIT_FINAL;
          end
        end
        CMD_RX_BYTE: begin
          if (phase == PH_WAIT_START) begin
            phase_next = (data_byte == CH_NAK) ? PH_ACK_PEND : PH_FAILED;
          end else if (phase == PH_WAIT_REPLY) begin
            if (data_byte == CH_ACK) begin
              block_number_next = block_number + 8'd1;
              fill_count_next   = 8'd0;
              phase_next        = final_block ? PH_EOT_PEND : PH_LOADING;
            end else if (data_byte == CH_CAN) begin
              phase_next = PH_CANCELLED;
            end else if (retries_left <= 8'd1) begin
              retries_left_next = 8'd0;
              phase_next        = PH_FAILED;
            end else begin
              retries_left_next = retries_left - 8'd1;
              send_index_next   = 8'd0;
              running_sum_next  = 8'd0;
              phase_next        = PH_SENDING;
            end
          end else if (phase == PH_WAIT_FINAL) begin
            phase_next = (data_byte == CH_ACK) ? PH_DONE : PH_DONE_NOACK;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // The store is read ahead: the address follows the next frame position,
  // so the data byte is waiting when its transmit slot arrives.
  assign raddr_full = send_index_next - DATA_START;

  assign store_req.we    = store_we;
  assign store_req.waddr = fill_count[STORE_AW-1:0];
  assign store_req.wdata = data_byte;
  assign store_req.raddr = raddr_full[STORE_AW-1:0];

  assign result.tx_valid       = tx_valid;
  assign result.tx_byte        = tx_byte;
  assign result.session_status = status_of_phase(phase_next);
  assign result.ready_for_data = (phase_next == PH_LOADING);
  assign result.current_block  = block_number_next;

endmodule

FILE: rtl/core/xmodem_checksum_block_sender.sv
// Top level of the XMODEM checksum sender with its result register.
//
// This block is the sender side of an XMODEM transfer with 128-byte blocks
// and an 8-bit additive checksum. Each input transfer carries one command:
// load a file byte, end of file, transmit slot free, or a byte received from
// the link. Every accepted input transfer produces exactly one result
// transfer that tells whether a byte goes out on the link now (tx_valid and
// tx_byte), the session status, whether file bytes are taken, and the current
// block number. The session starts when the receiver sends NAK, which is
// answered with ACK; file bytes then fill the block store, a short last block
// is padded with 0x1A, and each block is framed as SOH, number, inverted
// number, 128 data bytes and checksum, one byte per free transmit slot. ACK
// moves on, CAN cancels, any other reply resends until retry_limit
// transmissions have failed. After the last block EOT goes out and one final
// reply ends the session; a file whose length is a multiple of 128 gets no
// extra pad block. The block takes one item per clock cycle, and its result is
// registered; a new input is taken while the previous result waits, as long
// as out_ready frees the result register in the same cycle. The block store
// is a memory read one frame position ahead, so its registered read data is
// ready for each data byte. retry_limit sits at byte address 0 of the APB
// port; the user must write it only while the block is idle, and the block
// itself does not enforce this. A new value applies from the next block on.
module xmodem_checksum_block_sender (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic [2:0]  session_status,
  output logic        ready_for_data,
  output logic [7:0]  current_block,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import xcs_pkg::*;

  logic       in_fire;
  logic [7:0] retry_limit;
  logic [7:0] rd_data;
  store_req_t store_req;
  result_t    result;

  // A new item is taken whenever the result register is empty or is being
  // emptied in this cycle.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  xcs_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .retry_limit (retry_limit)
  );

  xcs_store u_store (
    .clk     (clk),
    .req     (store_req),
    .rd_data (rd_data)
  );

  xcs_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .cmd         (cmd),
    .data_byte   (data_byte),
    .retry_limit (retry_limit),
    .rd_data     (rd_data),
    .store_req   (store_req),
    .result      (result)
  );

  // Result register: holds one finished result until its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      tx_valid       <= result.tx_valid;
      tx_byte        <= result.tx_byte;
      session_status <= result.session_status;
      ready_for_data <= result.ready_for_data;
      current_block  <= result.current_block;
    end
  end

endmodule

FILE: rtl/core/xcs_checker.sv
// Port-level checker for the XMODEM checksum sender, bound to the top level.
`include "xmodem_checksum_block_sender_macros.svh"

module xcs_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        tx_valid,
  input logic [7:0]  tx_byte,
  input logic [2:0]  session_status,
  input logic        ready_for_data
);
  import xcs_pkg::*;

  // A result with nothing to send carries a zero byte.
  `XCS_ASSERT_IMP(a_idle_byte_zero, out_valid && !tx_valid, tx_byte == 8'd0)

  // File bytes are taken exactly while the session is loading.
  `XCS_ASSERT_IMP(a_ready_means_loading, out_valid,
                  ready_for_data == (session_status == ST_LOADING))

  // A stalled result stays in place.
  `XCS_ASSERT_NXT(a_result_holds, out_valid && !out_ready,
                  out_valid && $stable(tx_byte) && $stable(session_status))

  // An ended session keeps its status in the result that follows.
  `XCS_ASSERT_NXT(a_end_is_final,
                  out_valid && out_ready && session_status[2],
                  !out_valid || session_status == $past(session_status))

endmodule

bind xmodem_checksum_block_sender xcs_checker u_xcs_checker (.*);

FILE: tb/xmodem_checksum_block_sender_checker.sv
// Checker for the XMODEM checksum sender: predicts each result transfer and compares it.
`timescale 1ns / 1ps

module xmodem_checksum_block_sender_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        tx_valid,
  input  logic [7:0]  tx_byte,
  input  logic [2:0]  session_status,
  input  logic        ready_for_data,
  input  logic [7:0]  current_block,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output int          errors,
  output int          results_due
);
  import xcs_pkg::*;

  // Shadow copy of the sender's configuration and session state.
  logic [7:0] retry_cfg;
  logic [7:0] file_block [BLOCK_BYTES];
  logic [7:0] fill_cnt;
  logic [7:0] frame_pos;
  logic [7:0] sum_acc;
  logic [7:0] blk_num;
  logic [7:0] tries_left;
  phase_t     cur_phase;
  logic       last_block;

  result_t expected_results[$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic open_block(input logic last);
    last_block = last;
    frame_pos  = '0;
    sum_acc    = '0;
    tries_left = retry_cfg;
    cur_phase  = PH_SENDING;
  endtask

  task automatic predict_step(input cmd_t c, input logic [7:0] b, output result_t r);
    logic [7:0] idx;
    r = '0;
    case (c)
      CMD_LOAD: begin
        if (cur_phase == PH_LOADING && fill_cnt < BLOCK_BYTES_W) begin
          file_block[fill_cnt[STORE_AW-1:0]] = b;
          fill_cnt++;
          if (fill_cnt >= BLOCK_BYTES_W) open_block(1'b0);
        end
      end
      CMD_EOF: begin
        if (cur_phase == PH_LOADING) begin
          if (fill_cnt == 0) cur_phase = PH_EOT_PEND;
          else open_block(1'b1);
        end
      end
      CMD_TX_SLOT: begin
        if (cur_phase == PH_ACK_PEND) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = CH_ACK;
          fill_cnt   = '0;
          cur_phase  = PH_LOADING;
        end else if (cur_phase == PH_SENDING) begin
          r.tx_valid = 1'b1;
          if (frame_pos == 0) begin
            r.tx_byte = CH_SOH;
            sum_acc   = '0;
          end else if (frame_pos == 1) begin
            r.tx_byte = blk_num;
          end else if (frame_pos == 2) begin
            r.tx_byte = 8'd255 - blk_num;
          end else if (frame_pos < CHECKSUM_POS) begin
            // Positions past the loaded bytes of a short block carry padding.
            idx       = frame_pos - DATA_START;
            r.tx_byte = (idx < fill_cnt) ? file_block[idx[STORE_AW-1:0]] : CH_PAD;
            sum_acc   = sum_acc + r.tx_byte;
          end else begin
            r.tx_byte = sum_acc;
          end
          frame_pos++;
          if (frame_pos >= FRAME_LEN) cur_phase = PH_WAIT_REPLY;
        end else if (cur_phase == PH_EOT_PEND) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = CH_EOT;
          cur_phase  = PH_WAIT_FINAL;
        end
      end
      default: begin
        if (cur_phase == PH_WAIT_START) begin
          cur_phase = (b == CH_NAK) ? PH_ACK_PEND : PH_FAILED;
        end else if (cur_phase == PH_WAIT_REPLY) begin
          if (b == CH_ACK) begin
            blk_num++;
            fill_cnt  = '0;
            cur_phase = last_block ? PH_EOT_PEND : PH_LOADING;
          end else if (b == CH_CAN) begin
            cur_phase = PH_CANCELLED;
          end else if (tries_left <= 1) begin
            // A limit of zero behaves like a limit of one.
            tries_left = '0;
            cur_phase  = PH_FAILED;
          end else begin
            tries_left--;
            frame_pos = '0;
            sum_acc   = '0;
            cur_phase = PH_SENDING;
          end
        end else if (cur_phase == PH_WAIT_FINAL) begin
          cur_phase = (b == CH_ACK) ? PH_DONE : PH_DONE_NOACK;
        end
      end
    endcase

    case (cur_phase)
      PH_WAIT_START, PH_ACK_PEND:   r.session_status = ST_WAIT_START;
      PH_LOADING:                   r.session_status = ST_LOADING;
      PH_SENDING, PH_EOT_PEND:      r.session_status = ST_SENDING;
      PH_WAIT_REPLY, PH_WAIT_FINAL: r.session_status = ST_WAIT_REPLY;
      PH_DONE:                      r.session_status = ST_DONE;
      PH_CANCELLED:                 r.session_status = ST_CANCELLED;
      PH_DONE_NOACK:                r.session_status = ST_DONE_NOACK;
      default:                      r.session_status = ST_FAILED;
    endcase
    r.ready_for_data = (cur_phase == PH_LOADING);
    r.current_block  = blk_num;
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      retry_cfg  = RETRY_LIMIT_RESET;
      fill_cnt   = '0;
      frame_pos  = '0;
      sum_acc    = '0;
      blk_num    = 8'd1;
      tries_left = RETRY_LIMIT_RESET;
      cur_phase  = PH_WAIT_START;
      last_block = 1'b0;
      errors     = 0;
      expected_results.delete();
    end else begin
      // Results are retired before new inputs are predicted, so a result
      // can never be matched against the input taken at the same edge.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected, tx_byte", tx_byte, 0);
        end else begin
          want = expected_results.pop_front();
          if (tx_valid !== want.tx_valid)
            report_mismatch("tx_valid", tx_valid, want.tx_valid);
          if (tx_byte !== want.tx_byte)
            report_mismatch("tx_byte", tx_byte, want.tx_byte);
          if (session_status !== want.session_status)
            report_mismatch("session_status", session_status, want.session_status);
          if (ready_for_data !== want.ready_for_data)
            report_mismatch("ready_for_data", ready_for_data, want.ready_for_data);
          if (current_block !== want.current_block)
            report_mismatch("current_block", current_block, want.current_block);
        end
      end
      if (psel && penable && pwrite && pready && paddr == ADDR_RETRY_LIMIT)
        retry_cfg = pwdata[7:0];
      if (in_valid && in_ready) begin
        predict_step(cmd_t'(cmd), data_byte, want);
        expected_results.push_back(want);
      end
    end
    results_due = expected_results.size();
  end

endmodule

FILE: tb/xmodem_checksum_block_sender_tb.sv
// Top of the XMODEM checksum sender testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module xmodem_checksum_block_sender_tb;
  import xcs_pkg::*;

  // Cycles without any transfer on either channel before the run is called hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Full blocks keep coming until this many useful items were sent; a full
  // block with its frame is 261 items, so one block is sent.
  localparam int RANDOM_ITEMS   = 200;

  // Commands that act in a given phase; noise picks a command outside the mask.
  localparam logic [3:0] MASK_NONE = 4'b0000;
  localparam logic [3:0] MASK_FILE = 4'((1 << CMD_LOAD) | (1 << CMD_EOF));
  localparam logic [3:0] MASK_SLOT = 4'(1 << CMD_TX_SLOT);
  localparam logic [3:0] MASK_RX   = 4'(1 << CMD_RX_BYTE);

  // How the one session of the run is brought to its end.
  typedef enum logic [1:0] {
    END_FINAL_ACK   = 2'd0,
    END_FINAL_OTHER = 2'd1,
    END_CANCEL      = 2'd2,
    END_RETRY_OUT   = 2'd3
  } ending_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  cmd_t        cmd;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic [2:0]  session_status;
  logic        ready_for_data;
  logic [7:0]  current_block;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int errors;
  int results_due;

  // Idle bursts are switched on and off in long stretches; calm turns them off
  // for good in the last part of the run.
  bit         bursts_on = 1'b1;
  bit         calm = 1'b0;
  int         stall_left = 0;
  int         live_count = 0;
  int         allowance = 0;
  logic [7:0] cfg_limit = RETRY_LIMIT_RESET;

  xmodem_checksum_block_sender u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .tx_valid       (tx_valid),
    .tx_byte        (tx_byte),
    .session_status (session_status),
    .ready_for_data (ready_for_data),
    .current_block  (current_block),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  xmodem_checksum_block_sender_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .tx_valid       (tx_valid),
    .tx_byte        (tx_byte),
    .session_status (session_status),
    .ready_for_data (ready_for_data),
    .current_block  (current_block),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .errors         (errors),
    .results_due    (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Flip the idle bursts on and off so that some long stretches run at full rate.
  initial begin
    forever begin
      repeat ($urandom_range(100, 400)) @(negedge clk);
      bursts_on = !bursts_on;
    end
  end

  // The result side stalls in bursts while idle bursts are on.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (bursts_on && !calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // The watchdog ends the run when no transfer has happened for too long,
  // which also catches an expected result that never shows up.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Sends one input transfer, sometimes after an idle burst.
  // Valid is left high after the transfer; the next call either replaces the
  // payload or drops valid at the following falling edge.
  task automatic send_item(input cmd_t c, input logic [7:0] b, input bit live);
    int gap;
    gap = (bursts_on && !calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    cmd       <= c;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    if (live) live_count++;
  endtask

  // A command that the current phase ignores, with a random byte.
  task automatic send_noise(input logic [3:0] live_mask);
    int c;
    c = $urandom_range(0, 3);
    while (live_mask[c]) c = $urandom_range(0, 3);
    send_item(cmd_t'(c), 8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic maybe_noise(input logic [3:0] live_mask);
    if ($urandom_range(0, 9) == 0) send_noise(live_mask);
  endtask

  // Holds the sender back until every expected result has come out, then lets
  // the pipeline settle with a small margin.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // APB write of retry_limit: setup cycle, then access cycle. The upper data
  // bits are random since the register only keeps the low byte.
  task automatic write_retry_limit(input logic [7:0] v);
    drain_results();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_RETRY_LIMIT;
    pwdata  <= {24'($urandom), v};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_limit = v;
  endtask

  // Loads n file bytes; fewer than a full block is closed by end of file.
  // The block starts at that point, so its retry budget is fixed here.
  task automatic load_block(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      maybe_noise(MASK_FILE);
      if ($urandom_range(0, 7) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else b = 8'($urandom_range(0, 255));
      send_item(CMD_LOAD, b, 1'b1);
    end
    if (n < BLOCK_BYTES) begin
      maybe_noise(MASK_FILE);
      send_item(CMD_EOF, 8'($urandom_range(0, 255)), 1'b1);
    end
    allowance = (cfg_limit > 1) ? int'(cfg_limit) - 1 : 0;
  endtask

  // One free transmit slot per frame position: SOH, number, inverted number,
  // data and checksum.
  task automatic send_frame();
    repeat (FRAME_LEN) begin
      maybe_noise(MASK_SLOT);
      send_item(CMD_TX_SLOT, 8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic send_reply(input logic [7:0] b);
    maybe_noise(MASK_RX);
    send_item(CMD_RX_BYTE, b, 1'b1);
  endtask

  // A reply that forces a resend: neither ACK nor CAN, NAK at least half of the time.
  function automatic logic [7:0] pick_bad_reply();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == CH_ACK || b == CH_CAN) b = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 1) == 1) b = CH_NAK;
    return b;
  endfunction

  initial begin
    ending_t    ending;
    int         nfinal;
    int         bad;
    logic [7:0] b;
    bit         wrong_start;
    bit         empty_file;

    rst       = 1'b1;
    in_valid  = 1'b0;
    cmd       = CMD_LOAD;
    data_byte = 8'h00;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = ADDR_RETRY_LIMIT;
    pwdata    = 32'h0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Only one session fits in a run, so its shape is drawn up front: now and
    // then it opens with a wrong start byte or carries an empty file.
    wrong_start = ($urandom_range(0, 15) == 0);
    empty_file  = !wrong_start && ($urandom_range(0, 15) == 0);
    ending      = ending_t'($urandom_range(0, 3));

    write_retry_limit(8'd255);

    // Directed opening: commands out of place before the start NAK.
    send_item(CMD_LOAD, 8'hFF, 1'b0);
    send_item(CMD_EOF, 8'h00, 1'b0);
    send_item(CMD_TX_SLOT, 8'h5A, 1'b0);

    if (wrong_start) begin
      b = 8'($urandom_range(0, 255));
      while (b == CH_NAK) b = 8'($urandom_range(0, 255));
      send_item(CMD_RX_BYTE, b, 1'b1);
    end else begin
      send_item(CMD_RX_BYTE, CH_NAK, 1'b1);
      // While the start ACK is pending, status stays at wait start and only
      // a free slot does anything.
      send_item(CMD_RX_BYTE, 8'hFF, 1'b0);
      send_item(CMD_LOAD, 8'h00, 1'b0);
      send_item(CMD_EOF, 8'hA5, 1'b0);
      send_item(CMD_TX_SLOT, 8'h00, 1'b1);
      // Loading: no slot use and no reply is awaited, not even a CAN.
      send_item(CMD_TX_SLOT, 8'hFF, 1'b0);
      send_item(CMD_RX_BYTE, CH_CAN, 1'b0);

      if (!empty_file) begin
        // Full blocks with random content and a few resends, sent with the
        // maximum retry limit.
        while (live_count < RANDOM_ITEMS) begin
          load_block(BLOCK_BYTES);
          send_frame();
          bad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
          if (bad > allowance) bad = allowance;
          repeat (bad) begin
            send_reply(pick_bad_reply());
            send_frame();
          end
          send_reply(CH_ACK);
        end

        // Last block. A file that ends on a block boundary sends no pad block,
        // so an empty store at end of file goes straight to EOT. The retry
        // limit changes right after the maximum, now and then to zero or one.
        if (ending == END_RETRY_OUT) write_retry_limit(8'($urandom_range(0, 3)));
        else write_retry_limit(8'($urandom_range(0, 12)));
        case ($urandom_range(0, 3))
          0:       nfinal = 1;
          1:       nfinal = BLOCK_BYTES - 1;
          default: nfinal = $urandom_range(1, BLOCK_BYTES - 1);
        endcase
        if ((ending == END_FINAL_ACK || ending == END_FINAL_OTHER) &&
            $urandom_range(0, 2) == 0)
          nfinal = 0;
        load_block(nfinal);
        if (nfinal != 0) begin
          send_frame();
          case (ending)
            END_CANCEL: begin
              send_reply(CH_CAN);
            end
            END_RETRY_OUT: begin
              // Use up every resend, then one more bad reply fails the session.
              repeat (allowance) begin
                send_reply(pick_bad_reply());
                send_frame();
              end
              send_reply(pick_bad_reply());
            end
            default: begin
              bad = $urandom_range(0, 1);
              if (bad > allowance) bad = allowance;
              repeat (bad) begin
                send_reply(pick_bad_reply());
                send_frame();
              end
              send_reply(CH_ACK);
            end
          endcase
        end
      end else begin
        load_block(0);
      end

      // EOT and the final reply: ACK ends done, anything else done without ACK.
      if (empty_file || ending == END_FINAL_ACK || ending == END_FINAL_OTHER) begin
        maybe_noise(MASK_SLOT);
        send_item(CMD_TX_SLOT, 8'($urandom_range(0, 255)), 1'b1);
        if (ending == END_FINAL_ACK) begin
          send_reply(CH_ACK);
        end else begin
          b = 8'($urandom_range(0, 255));
          while (b == CH_ACK) b = 8'($urandom_range(0, 255));
          send_reply(b);
        end
      end
    end

    // The session has ended; every command must now be ignored. This last
    // stretch runs without idle bursts on either side.
    calm = 1'b1;
    repeat (30) send_noise(MASK_NONE);

    drain_results();
    repeat (4) @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
